>>> design/pmul_pkg.sv
// ----------------------------------------------------------------------------
// pmul_pkg
// Shared constants and types of the polynomial multiply core.
// ----------------------------------------------------------------------------
package pmul_pkg;

	localparam int MAX_DEGREE = 15;
	localparam int TAPS       = MAX_DEGREE + 1;
	localparam int DEG_W      = $clog2(MAX_DEGREE + 1);

	localparam int COEF_W     = 32;
	localparam int IDX_W      = 16;
	localparam int POS_W      = 4;
	localparam int CFG_DEG_W  = 4;
	localparam int ADDR_W     = 3;

	localparam logic [ADDR_W-1:0] ADDR_DEGREE = 3'd0;

	localparam logic MODE_LOAD   = 1'b0;
	localparam logic MODE_STREAM = 1'b1;

	typedef enum logic {
		ST_RUN,
		ST_FLUSH
	} seq_state_t;

	typedef struct packed {
		logic capture;
		logic step;
		logic flush;
		logic clear;
	} cell_ctrl_t;

endpackage

>>> design/pmul_cell.sv
// ----------------------------------------------------------------------------
// pmul_cell
// One tap of the transposed convolution: held multiplier coefficient,
// registered product and one partial sum handed down the chain.
// ----------------------------------------------------------------------------
module pmul_cell import pmul_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctrl_t        ctrl,
	input  logic              load_en,
	input  logic              tap_en,
	input  logic [COEF_W-1:0] coefficient,
	input  logic [COEF_W-1:0] sum_upper,
	output logic [COEF_W-1:0] sum
);

	logic [COEF_W-1:0] mult_q;
	logic [COEF_W-1:0] prod_s1;
	logic [COEF_W-1:0] psum_q;

	always_ff @(posedge clk) begin
		if (load_en) begin
			mult_q <= coefficient;
		end
		if (ctrl.capture) begin
			prod_s1 <= COEF_W'(coefficient * mult_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psum_q <= '0;
		end else if (ctrl.clear) begin
			psum_q <= '0;
		end else if (ctrl.step) begin
			psum_q <= sum_upper;
		end
	end

	assign sum = psum_q + ((tap_en && !ctrl.flush) ? prod_s1 : '0);

endmodule

>>> design/pmul_seq.sv
// ----------------------------------------------------------------------------
// pmul_seq
// Request sequencer: product stage valid, flush run, output index and
// the output register.
// ----------------------------------------------------------------------------
module pmul_seq import pmul_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_mode,
	input  logic              in_final,
	output logic              in_ready,
	output logic              load_req,
	input  logic [DEG_W-1:0]  degree,
	input  logic [COEF_W-1:0] sum0,
	output cell_ctrl_t        cell_ctrl,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [COEF_W-1:0] out_coef,
	output logic [IDX_W-1:0]  out_index,
	output logic              out_last
);

	seq_state_t        state_q;
	seq_state_t        state_nxt;
	logic              valid_s1;
	logic              final_s1;
	logic [DEG_W-1:0]  remain_q;
	logic [IDX_W-1:0]  count_q;
	logic              out_valid_q;
	logic [COEF_W-1:0] out_coef_q;
	logic [IDX_W-1:0]  out_index_q;
	logic              out_last_q;

	logic advance;
	logic s1_go;
	logic flush_go;
	logic accept;
	logic emit;
	logic emit_last;
	logic start_flush;

	always_comb begin
		advance     = !out_valid_q || out_ready;
		s1_go       = 1'b0;
		flush_go    = 1'b0;
		unique case (state_q)
			ST_RUN:   s1_go    = advance && valid_s1;
			ST_FLUSH: flush_go = advance;
			default:  s1_go    = 1'b0;
		endcase
		in_ready    = !valid_s1 || s1_go;
		accept      = in_valid && in_ready;
		load_req    = accept && (in_mode == MODE_LOAD);
		emit        = s1_go || flush_go;
		start_flush = s1_go && final_s1 && (degree != '0);
		emit_last   = s1_go ? (final_s1 && (degree == '0)) : (remain_q == DEG_W'(1));
		cell_ctrl.capture = accept && (in_mode == MODE_STREAM);
		cell_ctrl.step    = emit;
		cell_ctrl.flush   = flush_go;
		cell_ctrl.clear   = emit && emit_last;
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_RUN: begin
				if (start_flush) state_nxt = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (flush_go && remain_q == DEG_W'(1)) state_nxt = ST_RUN;
			end
			default: state_nxt = ST_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			valid_s1    <= 1'b0;
			final_s1    <= 1'b0;
			remain_q    <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cell_ctrl.capture) begin
				valid_s1 <= 1'b1;
				final_s1 <= in_final;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
			if (start_flush) begin
				remain_q <= degree;
			end else if (flush_go) begin
				remain_q <= remain_q - DEG_W'(1);
			end
			if (cell_ctrl.clear) begin
				count_q <= '0;
			end else if (emit && count_q != '1) begin
				count_q <= count_q + IDX_W'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_coef_q  <= sum0;
			out_index_q <= count_q;
			out_last_q  <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_coef  = out_coef_q;
	assign out_index = out_index_q;
	assign out_last  = out_last_q;

endmodule

>>> design/polynomial_multiply_core.sv
// ----------------------------------------------------------------------------
// polynomial_multiply_core
// Polynomial multiplier as a chain of transposed convolution taps.
// ----------------------------------------------------------------------------
// A stream product coefficient passes the tap product register, then the output register.
// Throughput: 1 request per cycle while the output does not stall and no flush runs;
// the product register in each tap sets the pace. A final request adds a flush of D outputs
// (D = degree); meanwhile one stream request and any number of load requests can still enter.
// Load requests give no result.
// Reset clears partial sums, output index, degree and all valids;
// multiplier coefficients hold no reset value until loaded.
module polynomial_multiply_core import pmul_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [39:0]       s_axis_tdata,  // position[3:0], coefficient[35:4], zero pad
	input  logic              s_axis_tuser,  // mode[0]
	input  logic              s_axis_tlast,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [47:0]       m_axis_tdata,  // product_coefficient[31:0], product_index[47:32]
	output logic              m_axis_tlast,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [CFG_DEG_W-1:0] degree_q;
	logic [DEG_W-1:0]     degree_eff;
	logic [POS_W-1:0]     position;
	logic [COEF_W-1:0]    coefficient;
	logic                 load_req;
	cell_ctrl_t           cell_ctrl;
	logic [COEF_W-1:0]    sums [TAPS];
	logic [COEF_W-1:0]    out_coef;
	logic [IDX_W-1:0]     out_index;
	logic                 reg_hit;

	assign position    = s_axis_tdata[POS_W-1:0];
	assign coefficient = s_axis_tdata[POS_W+COEF_W-1:POS_W];

	assign pready  = 1'b1;
	assign reg_hit = (paddr[ADDR_W-1:2] == ADDR_DEGREE[ADDR_W-1:2]);
	assign prdata  = reg_hit ? 32'(degree_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			degree_q <= pwdata[CFG_DEG_W-1:0];
		end
	end

	assign degree_eff = (int'(degree_q) > MAX_DEGREE) ? DEG_W'(MAX_DEGREE) : DEG_W'(degree_q);

	pmul_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_mode   (s_axis_tuser),
		.in_final  (s_axis_tlast),
		.in_ready  (s_axis_tready),
		.load_req  (load_req),
		.degree    (degree_eff),
		.sum0      (sums[0]),
		.cell_ctrl (cell_ctrl),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_coef  (out_coef),
		.out_index (out_index),
		.out_last  (m_axis_tlast)
	);

	for (genvar j = 0; j < TAPS; j++) begin : g_tap
		logic [COEF_W-1:0] upper;
		if (j == TAPS - 1) begin : g_end
			assign upper = '0;
		end else begin : g_mid
			assign upper = sums[j+1];
		end
		pmul_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (cell_ctrl),
			.load_en     (load_req && (int'(position) == j)),
			.tap_en      (j <= int'(degree_eff)),
			.coefficient (coefficient),
			.sum_upper   (upper),
			.sum         (sums[j])
		);
	end

	assign m_axis_tdata = {out_index, out_coef};

endmodule

>>> design/pmul_checker.sv
// ----------------------------------------------------------------------------
// pmul_checker
// Port-level checks of the polynomial multiply core.
// ----------------------------------------------------------------------------
module pmul_checker import pmul_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              m_axis_tvalid,
	input logic              m_axis_tready,
	input logic [47:0]       m_axis_tdata,
	input logic              m_axis_tlast,
	input logic              psel,
	input logic              penable,
	input logic              pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [31:0]       pwdata,
	input logic [31:0]       prdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output request changed while stalled");

	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast && m_axis_tdata[47:32] != 16'hFFFF |=>
			!m_axis_tvalid || m_axis_tdata[47:32] == $past(m_axis_tdata[47:32]) + 16'd1)
		else $error("product index did not advance by one");

	a_index_restart: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=>
			!m_axis_tvalid || m_axis_tdata[47:32] == 16'd0)
		else $error("product index did not restart after last coefficient");

	a_degree_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && paddr == ADDR_DEGREE |=>
			paddr != ADDR_DEGREE || prdata == 32'($past(pwdata[CFG_DEG_W-1:0])))
		else $error("degree register readback mismatch");

endmodule

bind polynomial_multiply_core pmul_checker u_pmul_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.psel          (psel),
	.penable       (penable),
	.pwrite        (pwrite),
	.paddr         (paddr),
	.pwdata        (pwdata),
	.prdata        (prdata)
);

>>> dv/polynomial_multiply_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_multiply_core_tb
// Streams load and multiplicand requests into the convolution core and checks
// every product coefficient, its index and its end-of-run mark against a
// cycle-free predictor of the transposed tap chain. Covers coefficient
// extremes, degree zero and fifteen, degree changes between requests, a long
// output hold-off and randomized traffic under several idle and stall mixes.
// ----------------------------------------------------------------------------
module polynomial_multiply_core_tb;
	import pmul_pkg::*;

	typedef struct packed {
		logic [COEF_W-1:0] coef;
		logic [IDX_W-1:0]  idx;
		logic              last;
	} product_t;

	localparam int WATCHDOG_LIMIT   = 1000;
	localparam int SETTLE_CYCLES    = 8;
	localparam int DRAIN_CYCLES     = 24;
	localparam int LONG_HOLD_CYCLES = 80;
	localparam int PHASE_ITEMS      = 45;

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [39:0]       s_axis_tdata;  // position[3:0], coefficient[35:4], zero pad
	logic              s_axis_tuser;  // mode[0]
	logic              s_axis_tlast;
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [47:0]       m_axis_tdata;  // product_coefficient[31:0], product_index[47:32]
	logic              m_axis_tlast;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	logic [COEF_W-1:0]    mult_coef [TAPS];
	logic [COEF_W-1:0]    psum [TAPS];
	logic [IDX_W-1:0]     out_idx;
	logic [CFG_DEG_W-1:0] cur_degree;
	product_t             expected_products [$];

	int mismatch_count;
	int items_sent;
	int idle_cycles;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_requests;
	int hold_served;
	int hold_left;

	polynomial_multiply_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input logic [47:0] got,
		input logic [47:0] want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		mismatch_count++;
	endtask

	function automatic void bump_index();
		if (out_idx != {IDX_W{1'b1}})
			out_idx++;
	endfunction

	function automatic void predict_products(input logic mode, input logic [POS_W-1:0] pos,
		input logic [COEF_W-1:0] coef, input logic fin);
		int                d;
		logic [COEF_W-1:0] first;
		logic [COEF_W-1:0] add;
		if (mode == MODE_LOAD) begin
			mult_coef[pos] = coef;
			return;
		end
		d = (int'(cur_degree) > MAX_DEGREE) ? MAX_DEGREE : int'(cur_degree);
		first = psum[0] + coef * mult_coef[0];
		for (int j = 0; j < TAPS - 1; j++) begin
			add = (j + 1 <= d) ? coef * mult_coef[j + 1] : '0;
			psum[j] = psum[j + 1] + add;
		end
		psum[TAPS - 1] = '0;
		expected_products.push_back('{first, out_idx, fin && d == 0});
		bump_index();
		if (fin) begin
			for (int j = 0; j < d; j++) begin
				expected_products.push_back('{psum[j], out_idx, j + 1 == d});
				bump_index();
			end
			for (int j = 0; j < TAPS; j++)
				psum[j] = '0;
			out_idx = '0;
		end
	endfunction

	always @(posedge clk) begin
		product_t got;
		product_t want;
		logic     busy;
		busy = 1'b0;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				busy = 1'b1;
				predict_products(s_axis_tuser, s_axis_tdata[3:0], s_axis_tdata[35:4],
					s_axis_tlast);
			end
			if (psel && penable && pready) begin
				busy = 1'b1;
				if (pwrite && paddr == ADDR_DEGREE)
					cur_degree = pwdata[CFG_DEG_W-1:0];
			end
			if (m_axis_tvalid && m_axis_tready) begin
				busy = 1'b1;
				got.coef = m_axis_tdata[31:0];
				got.idx  = m_axis_tdata[47:32];
				got.last = m_axis_tlast;
				if (expected_products.size() == 0) begin
					report_mismatch("unexpected product", m_axis_tdata, '0);
				end else begin
					want = expected_products.pop_front();
					if (got.coef !== want.coef)
						report_mismatch("product_coefficient", 48'(got.coef),
							48'(want.coef));
					if (got.idx !== want.idx)
						report_mismatch("product_index", 48'(got.idx), 48'(want.idx));
					if (got.last !== want.last)
						report_mismatch("last_of_run", 48'(got.last), 48'(want.last));
				end
			end
			if (busy)
				idle_cycles = 0;
			else if (expected_products.size() != 0 || s_axis_tvalid || psel)
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		m_axis_tready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left == 0 && hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left = LONG_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	function automatic logic [COEF_W-1:0] rand_coef();
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return '0;
			3: return '1;
			4: return $urandom_range(0, 15) - 8;
			default: return $urandom();
		endcase
	endfunction

	task automatic send_request(input logic mode, input logic [POS_W-1:0] pos,
		input logic [COEF_W-1:0] coef, input logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= mode;
		s_axis_tdata  <= {4'b0, coef, pos};
		s_axis_tlast  <= fin;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	task automatic stream_product(input int len);
		for (int i = 0; i < len; i++)
			send_request(MODE_STREAM, POS_W'($urandom_range(15)), rand_coef(), i == len - 1);
	endtask

	task automatic settle_block();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_products.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_degree(input logic [CFG_DEG_W-1:0] deg);
		logic [31:0] wdata;
		wdata = ($urandom() & 32'hFFFF_FFF0) | 32'(deg);
		settle_block();
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_DEGREE;
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[CFG_DEG_W-1:0] !== deg)
			report_mismatch("degree readback", 48'(prdata), 48'(deg));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic test_load_multiplier();
		logic [COEF_W-1:0] c;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		for (int p = 0; p < TAPS; p++) begin
			case (p)
				0: c = 32'h7FFF_FFFF;
				1: c = 32'h8000_0000;
				2: c = '1;
				3: c = '0;
				4: c = 32'd1;
				default: c = $urandom();
			endcase
			// final mark on a load must be ignored
			send_request(MODE_LOAD, POS_W'(p), c, p == 5);
		end
	endtask

	task automatic test_extreme_coefficients();
		set_degree(CFG_DEG_W'(MAX_DEGREE));
		send_request(MODE_STREAM, 4'hF, 32'h7FFF_FFFF, 1'b0);
		send_request(MODE_STREAM, 4'h0, 32'h8000_0000, 1'b0);
		send_request(MODE_STREAM, 4'hA, 32'hFFFF_FFFF, 1'b0);
		send_request(MODE_STREAM, 4'h5, 32'h0000_0000, 1'b1);
	endtask

	task automatic test_degree_zero();
		set_degree(4'd0);
		send_request(MODE_STREAM, 4'h3, rand_coef(), 1'b1);
		stream_product(3);
	endtask

	task automatic test_degree_change();
		set_degree(4'd3);
		stream_product(0);
		send_request(MODE_STREAM, 4'h0, rand_coef(), 1'b0);
		send_request(MODE_STREAM, 4'h0, rand_coef(), 1'b0);
		set_degree(4'd6);
		send_request(MODE_LOAD, 4'h1, rand_coef(), 1'b0);
		send_request(MODE_STREAM, 4'h0, rand_coef(), 1'b0);
		set_degree(4'd10);
		send_request(MODE_STREAM, 4'h0, rand_coef(), 1'b0);
		send_request(MODE_STREAM, 4'h0, rand_coef(), 1'b0);
		// drop the degree so stale sums above it shift down
		set_degree(4'd2);
		send_request(MODE_STREAM, 4'h0, rand_coef(), 1'b1);
	endtask

	task automatic test_output_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		set_degree(CFG_DEG_W'(MAX_DEGREE));
		hold_requests++;
		stream_product(40);
		settle_block();
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct);
		int start;
		int len;
		settle_block();
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		start = items_sent;
		while (items_sent - start < PHASE_ITEMS) begin
			if ($urandom_range(99) < 25) begin
				case ($urandom_range(3))
					0: set_degree(4'd0);
					1: set_degree(CFG_DEG_W'(MAX_DEGREE));
					default: set_degree(CFG_DEG_W'($urandom_range(MAX_DEGREE)));
				endcase
			end
			if ($urandom_range(99) < 30)
				repeat ($urandom_range(1, 3))
					send_request(MODE_LOAD, POS_W'($urandom_range(15)), rand_coef(),
						1'($urandom_range(1)));
			len = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 5);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(99) < 8)
					send_request(MODE_LOAD, POS_W'($urandom_range(15)), rand_coef(),
						1'($urandom_range(1)));
				if (i > 0 && $urandom_range(99) < 5)
					set_degree(CFG_DEG_W'($urandom_range(MAX_DEGREE)));
				send_request(MODE_STREAM, POS_W'($urandom_range(15)), rand_coef(),
					i == len - 1);
			end
		end
	endtask

	initial begin
		for (int j = 0; j < TAPS; j++) begin
			mult_coef[j] = '0;
			psum[j] = '0;
		end
		out_idx        = '0;
		cur_degree     = '0;
		mismatch_count = 0;
		items_sent     = 0;
		idle_cycles    = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_requests  = 0;
		hold_served    = 0;
		hold_left      = 0;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= MODE_LOAD;
		s_axis_tlast  <= 1'b0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_load_multiplier();
		test_extreme_coefficients();
		test_degree_zero();
		test_degree_change();
		test_output_backpressure();
		test_random_traffic(0, 0);
		test_random_traffic(45, 0);
		test_random_traffic(0, 45);
		test_random_traffic(21, 21);

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_products.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> filelist.f
design/pmul_pkg.sv
design/pmul_cell.sv
design/pmul_seq.sv
design/polynomial_multiply_core.sv
design/pmul_checker.sv
dv/polynomial_multiply_core_tb.sv
